@@ sv/ust_pkg.sv @@
`timescale 1ns / 1ps

package ust_pkg;

	localparam int CAPACITY    = 64;
	localparam int ENTRY_WIDTH = 32;
	localparam int IDX_W       = 6;
	localparam int CNT_W       = 7;
	localparam int OP_W        = 4;
	localparam int ST_W        = 3;
	localparam int IN_W        = 48;
	localparam int OUT_W       = 48;

	localparam logic [OP_W-1:0] OP_CLEAR       = 4'd0;
	localparam logic [OP_W-1:0] OP_APPEND      = 4'd1;
	localparam logic [OP_W-1:0] OP_WRITE       = 4'd2;
	localparam logic [OP_W-1:0] OP_READ        = 4'd3;
	localparam logic [OP_W-1:0] OP_POP         = 4'd4;
	localparam logic [OP_W-1:0] OP_REMOVE      = 4'd5;
	localparam logic [OP_W-1:0] OP_FIND_FIRST  = 4'd6;
	localparam logic [OP_W-1:0] OP_FIND_LAST   = 4'd7;
	localparam logic [OP_W-1:0] OP_FIND_ADD    = 4'd8;
	localparam logic [OP_W-1:0] OP_FIND_REMOVE = 4'd9;

	localparam logic [ST_W-1:0] ST_OK    = 3'd0;
	localparam logic [ST_W-1:0] ST_MISS  = 3'd1;
	localparam logic [ST_W-1:0] ST_RANGE = 3'd2;
	localparam logic [ST_W-1:0] ST_FULL  = 3'd3;
	localparam logic [ST_W-1:0] ST_EMPTY = 3'd4;

	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAPACITY);

endpackage

@@ sv/unordered_set_table.sv @@
`timescale 1ns / 1ps

// clear, append, write, pop, spare codes and remove of the last entry go straight to S_RESP;
// an in-range read passes S_RDWAIT and a remove that moves the last entry passes S_MOVE
// searches: one stored entry compared per cycle on the read port
// one transaction in flight; next accepted the cycle after the result enters the output
// register, which is held off while the output is stalled
// reset: count and handshake state cleared; entries undefined until written
module unordered_set_table (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_axis_tvalid,
	output logic                       s_axis_tready,
	input  logic [ust_pkg::IN_W-1:0]   s_axis_tdata,  // operation, index, value, zero pad
	output logic                       m_axis_tvalid,
	input  logic                       m_axis_tready,
	output logic [ust_pkg::OUT_W-1:0]  m_axis_tdata   // status, found_index, read_data, count
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_SCAN = 3'd1;
	localparam logic [2:0] S_RDWAIT = 3'd2;
	localparam logic [2:0] S_MOVE = 3'd3;
	localparam logic [2:0] S_RESP = 3'd4;

	logic [2:0] state_q;

	logic [ust_pkg::ENTRY_WIDTH-1:0] mem [ust_pkg::CAPACITY];
	logic [ust_pkg::ENTRY_WIDTH-1:0] rdata_s1;
	logic                            mem_we;
	logic [ust_pkg::IDX_W-1:0]       mem_waddr;
	logic [ust_pkg::IDX_W-1:0]       mem_raddr;
	logic [ust_pkg::ENTRY_WIDTH-1:0] mem_wdata;

	logic [ust_pkg::CNT_W-1:0]       count_q;
	logic [ust_pkg::OP_W-1:0]        op_q;
	logic [ust_pkg::ENTRY_WIDTH-1:0] key_q;
	logic [ust_pkg::IDX_W-1:0]       move_dst_q;
	logic [ust_pkg::IDX_W-1:0]       scan_ptr_q;
	logic [ust_pkg::CNT_W-1:0]       scan_left_q;
	logic                            scan_down_q;
	logic                            rd_vld_s1;
	logic [ust_pkg::IDX_W-1:0]       rd_idx_s1;

	logic [ust_pkg::ST_W-1:0]        res_status_q;
	logic [ust_pkg::IDX_W-1:0]       res_found_q;
	logic [ust_pkg::ENTRY_WIDTH-1:0] res_data_q;

	logic                            out_valid_q;
	logic [ust_pkg::ST_W-1:0]        out_status_q;
	logic [ust_pkg::IDX_W-1:0]       out_found_q;
	logic [ust_pkg::ENTRY_WIDTH-1:0] out_data_q;
	logic [ust_pkg::CNT_W-1:0]       out_count_q;

	logic [ust_pkg::OP_W-1:0]        in_op;
	logic [ust_pkg::IDX_W-1:0]       in_idx;
	logic [ust_pkg::ENTRY_WIDTH-1:0] in_val;
	logic                            accept;
	logic                            idx_ok;
	logic                            is_full;
	logic [ust_pkg::IDX_W-1:0]       last_idx;
	logic [ust_pkg::IDX_W-1:0]       fill_idx;
	logic                            scan_hit;
	logic                            scan_miss;
	logic                            out_free;

	assign in_op  = s_axis_tdata[3:0];
	assign in_idx = s_axis_tdata[9:4];
	assign in_val = s_axis_tdata[41:10];

	assign s_axis_tready = (state_q == S_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign idx_ok        = {1'b0, in_idx} < count_q;
	assign is_full       = (count_q == ust_pkg::CNT_FULL);
	assign last_idx      = ust_pkg::IDX_W'(count_q - 7'd1);
	assign fill_idx      = count_q[ust_pkg::IDX_W-1:0];
	assign scan_hit      = rd_vld_s1 && (rdata_s1 == key_q);
	assign scan_miss     = !rd_vld_s1 && (scan_left_q == '0);
	assign out_free      = !out_valid_q || m_axis_tready;

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {out_count_q, out_data_q, out_found_q, out_status_q};

	// memory port control
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = fill_idx;
		mem_wdata = in_val;
		mem_raddr = scan_ptr_q;
		unique case (state_q) inside
			S_IDLE: begin
				if (accept) begin
					case (in_op)
						ust_pkg::OP_APPEND: begin
							mem_we = !is_full;
						end
						ust_pkg::OP_WRITE: begin
							mem_we    = idx_ok;
							mem_waddr = in_idx;
						end
						ust_pkg::OP_READ: begin
							mem_raddr = in_idx;
						end
						ust_pkg::OP_REMOVE: begin
							mem_raddr = last_idx;
						end
						default: begin
						end
					endcase
				end
			end
			S_SCAN: begin
				if (scan_hit) begin
					mem_raddr = last_idx;
				end else if (scan_miss && op_q == ust_pkg::OP_FIND_ADD && !is_full) begin
					mem_we    = 1'b1;
					mem_wdata = key_q;
				end
			end
			S_MOVE: begin
				mem_we    = 1'b1;
				mem_waddr = move_dst_q;
				mem_wdata = rdata_s1;
			end
			S_RDWAIT, S_RESP: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rdata_s1 <= mem[mem_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			rd_vld_s1   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					rd_vld_s1 <= 1'b0;
					if (accept) begin
						op_q         <= in_op;
						key_q        <= in_val;
						res_status_q <= ust_pkg::ST_OK;
						res_found_q  <= '0;
						res_data_q   <= '0;
						state_q      <= S_RESP;
						unique case (in_op) inside
							ust_pkg::OP_CLEAR: begin
								count_q <= '0;
							end
							ust_pkg::OP_APPEND: begin
								if (is_full) begin
									res_status_q <= ust_pkg::ST_FULL;
								end else begin
									count_q <= count_q + 7'd1;
								end
							end
							ust_pkg::OP_WRITE: begin
								if (!idx_ok) begin
									res_status_q <= ust_pkg::ST_RANGE;
								end
							end
							ust_pkg::OP_READ: begin
								if (!idx_ok) begin
									res_status_q <= ust_pkg::ST_RANGE;
								end else begin
									state_q <= S_RDWAIT;
								end
							end
							ust_pkg::OP_POP: begin
								if (count_q == '0) begin
									res_status_q <= ust_pkg::ST_EMPTY;
								end else begin
									count_q <= count_q - 7'd1;
								end
							end
							ust_pkg::OP_REMOVE: begin
								if (!idx_ok) begin
									res_status_q <= ust_pkg::ST_RANGE;
								end else if (in_idx == last_idx) begin
									count_q <= count_q - 7'd1;
								end else begin
									move_dst_q <= in_idx;
									state_q    <= S_MOVE;
								end
							end
							[ust_pkg::OP_FIND_FIRST:ust_pkg::OP_FIND_REMOVE]: begin
								scan_down_q <= (in_op != ust_pkg::OP_FIND_FIRST);
								scan_ptr_q  <= (in_op == ust_pkg::OP_FIND_FIRST) ? '0 : last_idx;
								scan_left_q <= count_q;
								state_q     <= S_SCAN;
							end
							default: begin
							end
						endcase
					end
				end
				S_SCAN: begin
					if (scan_left_q != '0) begin
						rd_vld_s1   <= 1'b1;
						rd_idx_s1   <= scan_ptr_q;
						scan_ptr_q  <= scan_down_q ? scan_ptr_q - 6'd1 : scan_ptr_q + 6'd1;
						scan_left_q <= scan_left_q - 7'd1;
					end else begin
						rd_vld_s1 <= 1'b0;
					end
					if (scan_hit) begin
						rd_vld_s1   <= 1'b0;
						res_found_q <= rd_idx_s1;
						state_q     <= S_RESP;
						case (op_q)
							ust_pkg::OP_FIND_ADD: begin
								res_status_q <= ust_pkg::ST_MISS;
							end
							ust_pkg::OP_FIND_REMOVE: begin
								if (rd_idx_s1 == last_idx) begin
									count_q <= count_q - 7'd1;
								end else begin
									move_dst_q <= rd_idx_s1;
									state_q    <= S_MOVE;
								end
							end
							default: begin
							end
						endcase
					end else if (scan_miss) begin
						state_q <= S_RESP;
						if (op_q == ust_pkg::OP_FIND_ADD) begin
							if (is_full) begin
								res_status_q <= ust_pkg::ST_FULL;
							end else begin
								res_found_q <= fill_idx;
								count_q     <= count_q + 7'd1;
							end
						end else begin
							res_status_q <= ust_pkg::ST_MISS;
						end
					end
				end
				S_RDWAIT: begin
					res_data_q <= rdata_s1;
					state_q    <= S_RESP;
				end
				S_MOVE: begin
					count_q <= count_q - 7'd1;
					state_q <= S_RESP;
				end
				S_RESP: begin
					if (out_free) begin
						out_valid_q  <= 1'b1;
						out_status_q <= res_status_q;
						out_found_q  <= res_found_q;
						out_data_q   <= res_data_q;
						out_count_q  <= count_q;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= ust_pkg::CNT_FULL)
		else $error("count above capacity");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != $past(count_q)) |-> (count_q == $past(count_q) + 7'd1 ||
			count_q == $past(count_q) - 7'd1 || count_q == '0))
		else $error("count moved by more than one");

	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_status_q == ust_pkg::ST_FULL) |-> (out_count_q == ust_pkg::CNT_FULL))
		else $error("full reported below capacity");

	a_scan_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN && scan_left_q != '0) |-> ({1'b0, scan_ptr_q} < count_q))
		else $error("scan read outside valid entries");

	a_move_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MOVE) |-> ({1'b0, move_dst_q} < count_q - 7'd1))
		else $error("move target not below last entry");

endmodule
